// ===== hw/rtl/ebb_pkg.sv =====
// Shared constants, types and helper functions of the line box blur.
`timescale 1ns / 1ps

package ebb_pkg;

    // Window store geometry
    localparam int MAX_WIDTH = 64;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CHANNELS  = 4;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = CHANNELS * CHAN_W;

    // Arithmetic widths
    localparam int SUM_W  = 14;
    localparam int COV_W  = $clog2(MAX_WIDTH + 1);
    localparam int OFF_W  = $clog2(MAX_WIDTH / 2 + 1);
    localparam int NCH_W  = 3;
    localparam int BW_W   = 7;
    localparam int QUO_W  = CHAN_W + 1;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int NUM_W  = SUM_W + 1;
    localparam int DVS_W  = COV_W + QUO_W - 1;
    localparam int DIV_W  = (NUM_W > DVS_W) ? NUM_W : DVS_W;

    // Configuration port
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WIN_WIDTH     = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_EVEN_SIDE     = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = REG_IDX_W'(2);

    localparam logic [BW_W-1:0]  RST_WIN_WIDTH     = BW_W'(3);
    localparam logic             RST_EVEN_SIDE     = 1'b0;
    localparam logic [NCH_W-1:0] RST_CHANNEL_COUNT = NCH_W'(3);

    typedef struct packed {
        logic [BW_W-1:0]  win_width;
        logic             even_side;
        logic [NCH_W-1:0] channel_count;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [COV_W-1:0] cov;
    } t_div_req;

    typedef logic [CHANNELS-1:0][CHAN_W-1:0] t_byte_vec;
    typedef logic [CHANNELS-1:0][SUM_W-1:0]  t_sum_vec;

    // Clamp the programmed width into 1..MAX_WIDTH
    function automatic logic [COV_W-1:0] eff_width(input logic [BW_W-1:0] bw);
        logic [COV_W-1:0] w;
        if (bw == '0) begin
            w = COV_W'(1);
        end else if (int'(bw) > MAX_WIDTH) begin
            w = COV_W'(MAX_WIDTH);
        end else begin
            w = COV_W'(bw);
        end
        return w;
    endfunction

    // Outputs trail the input by this many pixels
    function automatic logic [OFF_W-1:0] eff_offset(input logic [COV_W-1:0] w,
                                                     input logic side);
        logic [COV_W-1:0] half;
        logic [OFF_W-1:0] off;
        half = w >> 1;
        if (w[0] || !side) begin
            off = OFF_W'(half);
        end else begin
            off = OFF_W'(half - 1'b1);
        end
        return off;
    endfunction

    // Clamp the channel count to the lanes that exist
    function automatic logic [NCH_W-1:0] eff_chans(input logic [NCH_W-1:0] cnt);
        logic [NCH_W-1:0] n;
        if (int'(cnt) > CHANNELS) begin
            n = NCH_W'(CHANNELS);
        end else begin
            n = cnt;
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/ebb_ram.sv =====
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps

module ebb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ebb_cfg.sv =====
// APB-style configuration registers of the line box blur.
`timescale 1ns / 1ps

module ebb_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ebb_pkg::PADDR_W-1:0] paddr,
    input  logic [ebb_pkg::APB_W-1:0] pwdata,
    output logic [ebb_pkg::APB_W-1:0] prdata,
    output logic                      pready,
    output ebb_pkg::t_cfg             o_cfg
);

    import ebb_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Capture register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_width     <= RST_WIN_WIDTH;
            r_cfg.even_side     <= RST_EVEN_SIDE;
            r_cfg.channel_count <= RST_CHANNEL_COUNT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIN_WIDTH:     r_cfg.win_width     <= pwdata[BW_W-1:0];
                REG_EVEN_SIDE:     r_cfg.even_side     <= pwdata[0];
                REG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[NCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_WIN_WIDTH:     prdata = APB_W'(r_cfg.win_width);
            REG_EVEN_SIDE:     prdata = APB_W'(r_cfg.even_side);
            REG_CHANNEL_COUNT: prdata = APB_W'(r_cfg.channel_count);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/ebb_div.sv =====
// Four-lane restoring divider: rounded average of each channel sum, saturated.
`timescale 1ns / 1ps

module ebb_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ebb_pkg::t_div_req   i_req,
    input  ebb_pkg::t_sum_vec   i_sums,
    output logic                o_done,
    output ebb_pkg::t_byte_vec  o_quot
);

    import ebb_pkg::*;

    logic                             r_busy;
    logic                             r_done;
    logic [CNT_W-1:0]                 r_cnt;
    logic [DIV_W-1:0]                 r_dvs;
    logic [CHANNELS-1:0][DIV_W-1:0]   r_rem;
    logic [CHANNELS-1:0][QUO_W-1:0]   r_q;
    logic [CHANNELS-1:0]              ge;

    // Trial compare per lane
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            ge[c] = r_rem[c] >= r_dvs;
        end
    end

    // Step counter: one quotient bit per cycle, top bit flags saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Load the rounded numerators, then subtract the shifted divisor
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvs <= DIV_W'(i_req.cov) << (QUO_W - 1);
            for (int c = 0; c < CHANNELS; c++) begin
                r_rem[c] <= DIV_W'(i_sums[c]) + DIV_W'(i_req.cov >> 1);
                r_q[c]   <= '0;
            end
        end else if (r_busy) begin
            r_dvs <= r_dvs >> 1;
            for (int c = 0; c < CHANNELS; c++) begin
                if (ge[c]) begin
                    r_rem[c] <= r_rem[c] - r_dvs;
                end
                r_q[c] <= {r_q[c][QUO_W-2:0], ge[c]};
            end
        end
    end

    // Saturate to the channel range
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            o_quot[c] = r_q[c][QUO_W-1] ? {CHAN_W{1'b1}} : r_q[c][CHAN_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// ===== hw/rtl/edge_normalized_box_blur_line.sv =====
// Top level: line box blur with edge-normalized, rounded averaging over a pixel window.
// Each request is read, updated and, where it releases a result, divided by the nine-step
// shared divider and handed to the output register; a line end repeats this for every flush
// result. No new request is taken until the previous one and its flush results are done.
// Reset: synchronous, active low; clears the sequencer, channel sums, line position, write
// slot and output valid. The window store is not cleared; only written entries are read.
`timescale 1ns / 1ps

module edge_normalized_box_blur_line (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input pixel channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ebb_pkg::CHAN_W-1:0]   i_chan_a_in,
    input  logic [ebb_pkg::CHAN_W-1:0]   i_chan_b_in,
    input  logic [ebb_pkg::CHAN_W-1:0]   i_chan_c_in,
    input  logic [ebb_pkg::CHAN_W-1:0]   i_chan_d_in,
    input  logic                         i_line_end,
    // output pixel channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ebb_pkg::CHAN_W-1:0]   o_chan_a_out,
    output logic [ebb_pkg::CHAN_W-1:0]   o_chan_b_out,
    output logic [ebb_pkg::CHAN_W-1:0]   o_chan_c_out,
    output logic [ebb_pkg::CHAN_W-1:0]   o_chan_d_out,
    output logic                         o_out_line_end,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ebb_pkg::PADDR_W-1:0]  paddr,
    input  logic [ebb_pkg::APB_W-1:0]    pwdata,
    output logic [ebb_pkg::APB_W-1:0]    prdata,
    output logic                         pready
);

    import ebb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    t_cfg              cfg;
    logic [2:0]        r_state;
    t_byte_vec         r_pix;
    logic              r_end;
    logic [COV_W-1:0]  r_w;
    logic [OFF_W-1:0]  r_off;
    logic [NCH_W-1:0]  r_nch;
    logic [OFF_W-1:0]  r_k;
    logic [COV_W-1:0]  r_pos;
    logic [ADDR_W-1:0] r_slot;
    t_sum_vec          r_sums;
    t_sum_vec          n_sums;
    logic [COV_W-1:0]  r_cov;
    logic              r_div_start;
    logic              r_out_valid;
    t_byte_vec         r_out_pix;
    logic              r_out_last;

    logic              in_acc;
    logic [ADDR_W-1:0] rd_addr;
    t_byte_vec         rd_data;
    logic [COV_W:0]    pk;
    logic [COV_W:0]    pk1;
    logic [COV_W-1:0]  wk;
    logic [COV_W-1:0]  cov;
    logic              take;
    logic              emit;
    logic              is_first;
    logic              last_k;
    logic              out_free;
    logic              finish;
    t_div_req          div_req;
    logic              div_done;
    t_byte_vec         quot;

    ebb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Window position of the current flush step
    assign pk       = {1'b0, r_pos} + (COV_W + 1)'(r_k);
    assign pk1      = {1'b0, r_pos} + 1'b1;
    assign wk       = r_w - COV_W'(r_k);
    assign cov      = (pk1 < {1'b0, wk}) ? pk1[COV_W-1:0] : wk;
    assign take     = pk >= {1'b0, r_w};
    assign emit     = pk >= (COV_W + 1)'(r_off);
    assign is_first = (r_k == '0);
    assign last_k   = !r_end || (r_k == r_off);
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = ((r_state == S_MOD) && !emit && last_k) ||
                      ((r_state == S_OUT) && out_free && last_k);

    // Oldest pixel leaving the window
    assign rd_addr = r_slot - r_w[ADDR_W-1:0] + ADDR_W'(r_k);

    ebb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_MOD) && is_first),
        .i_waddr (r_slot),
        .i_wdata (r_pix),
        .i_re    (r_state == S_RD),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Drop the leaving pixel, add the new one, on the lanes in use
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (NCH_W'(c) < r_nch) begin
                n_sums[c] = r_sums[c]
                          - SUM_W'(take ? rd_data[c] : CHAN_W'(0))
                          + SUM_W'(is_first ? r_pix[c] : CHAN_W'(0));
            end else begin
                n_sums[c] = r_sums[c];
            end
        end
    end

    assign div_req.start = r_div_start;
    assign div_req.cov   = r_cov;

    ebb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_sums  (r_sums),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // Sequencer: read, update, divide and hand off when a result is due, repeat for each flush step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_pos       <= '0;
            r_slot      <= '0;
            r_sums      <= '0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_k     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_sums <= n_sums;
                    if (emit) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end else if (last_k) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (last_k) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // Advance the line position; a line end restarts the line
            if (finish) begin
                r_slot <= r_slot + 1'b1;
                if (r_end) begin
                    r_pos  <= '0;
                    r_sums <= '0;
                end else if (r_pos < COV_W'(MAX_WIDTH)) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    // Hold the request and the settings it runs under
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix <= {i_chan_d_in, i_chan_c_in, i_chan_b_in, i_chan_a_in};
            r_end <= i_line_end;
            r_w   <= eff_width(cfg.win_width);
            r_off <= eff_offset(eff_width(cfg.win_width), cfg.even_side);
            r_nch <= eff_chans(cfg.channel_count);
        end
        if ((r_state == S_MOD) && emit) begin
            r_cov <= cov;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_out_pix[c] <= (NCH_W'(c) < r_nch) ? quot[c] : CHAN_W'(0);
            end
            r_out_last <= r_end && (r_k == r_off);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_chan_a_out   = r_out_pix[0];
    assign o_chan_b_out   = r_out_pix[1];
    assign o_chan_c_out   = r_out_pix[2];
    assign o_chan_d_out   = r_out_pix[3];
    assign o_out_line_end = r_out_last;

endmodule

// ===== hw/rtl/ebb_checker.sv =====
// Port-level checks of the line box blur, bound to the top level.
`timescale 1ns / 1ps

module ebb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_chan_a_out,
    input logic [7:0] o_chan_b_out,
    input logic [7:0] o_chan_c_out,
    input logic [7:0] o_chan_d_out,
    input logic       o_out_line_end
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_chan_a_out) &&
        $stable(o_chan_b_out) && $stable(o_chan_c_out) && $stable(o_chan_d_out) &&
        $stable(o_out_line_end))
        else $error("stalled result changed");

    // An accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a request");

    // A result only appears at the end of a busy stretch through the divider
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall) && $past(o_in_stall, 3))
        else $error("result without a preceding divide");

    // Leaving reset, the block is idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind edge_normalized_box_blur_line ebb_checker u_ebb_checker (.*);

// ===== bench/edge_normalized_box_blur_line_tb.sv =====
// Self-checking testbench for the edge-normalized line box blur: directed lines, random lines.
`timescale 1ns / 1ps

module edge_normalized_box_blur_line_tb;
    import ebb_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LONG_LINE     = MAX_WIDTH + 36;

    typedef struct packed {
        t_byte_vec lane;
        logic      last;
    } t_blur_px;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [CHAN_W-1:0] i_chan_a_in = '0;
    logic [CHAN_W-1:0] i_chan_b_in = '0;
    logic [CHAN_W-1:0] i_chan_c_in = '0;
    logic [CHAN_W-1:0] i_chan_d_in = '0;
    logic              i_line_end  = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [CHAN_W-1:0] o_chan_a_out;
    logic [CHAN_W-1:0] o_chan_b_out;
    logic [CHAN_W-1:0] o_chan_c_out;
    logic [CHAN_W-1:0] o_chan_d_out;
    logic              o_out_line_end;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr  = '0;
    logic [APB_W-1:0]  pwdata  = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    // Blur model state: pixel ring, per-lane running sums, line position
    logic [PIX_W-1:0] px_ring [MAX_WIDTH];
    logic [SUM_W-1:0] lane_sum [CHANNELS];
    int unsigned      line_pos;
    int unsigned      ring_slot;
    logic [BW_W-1:0]  set_width;
    logic             set_lean_right;
    logic [NCH_W-1:0] set_lanes;

    t_blur_px    blur_expect [$];
    int          err_count      = 0;
    int unsigned cycle_count    = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;

    edge_normalized_box_blur_line uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_chan_a_in    (i_chan_a_in),
        .i_chan_b_in    (i_chan_b_in),
        .i_chan_c_in    (i_chan_c_in),
        .i_chan_d_in    (i_chan_d_in),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_chan_a_out   (o_chan_a_out),
        .o_chan_b_out   (o_chan_b_out),
        .o_chan_c_out   (o_chan_c_out),
        .o_chan_d_out   (o_chan_d_out),
        .o_out_line_end (o_out_line_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Remove the pixel leaving the window from the lane sums
    function automatic void drop_pixel(int unsigned slot, int unsigned nch);
        logic [PIX_W-1:0] px;
        px = px_ring[slot % MAX_WIDTH];
        for (int c = 0; c < nch; c++) begin
            lane_sum[c] = lane_sum[c] - px[CHAN_W*c +: CHAN_W];
        end
    endfunction

    // Queue the rounded, saturated average over the covered pixels
    function automatic void queue_average(int unsigned cov, int unsigned nch, logic last);
        t_blur_px    px;
        int unsigned v;
        px.lane = '0;
        px.last = last;
        for (int c = 0; c < CHANNELS; c++) begin
            if (c < nch) begin
                v = lane_sum[c];
                v = (v + cov / 2) / cov;
                if (v > 255) begin
                    v = 255;
                end
                px.lane[c] = CHAN_W'(v);
            end
        end
        blur_expect.push_back(px);
    endfunction

    // Advance the window by one accepted pixel and queue the averages it releases
    function automatic void predict_blur(t_byte_vec pix, logic last);
        int unsigned w;
        int unsigned off;
        int unsigned nch;
        int unsigned p;
        int unsigned slot;
        w = set_width;
        if (w == 0) begin
            w = 1;
        end else if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        if (w % 2 == 1) begin
            off = (w - 1) / 2;
        end else if (set_lean_right) begin
            off = w / 2 - 1;
        end else begin
            off = w / 2;
        end
        nch  = (set_lanes > CHANNELS) ? CHANNELS : set_lanes;
        p    = line_pos;
        slot = ring_slot;

        if (p >= w) drop_pixel(slot + MAX_WIDTH - w, nch);
        px_ring[slot] = pix;
        for (int c = 0; c < nch; c++) begin
            lane_sum[c] = lane_sum[c] + pix[c];
        end
        if (p >= off) queue_average((p + 1 < w) ? p + 1 : w, nch, last && off == 0);

        // Flush the trailing outputs of the line
        if (last) begin
            for (int unsigned k = 1; k <= off; k++) begin
                if (p + k >= w) drop_pixel(slot + MAX_WIDTH - w + k, nch);
                if (p + k >= off) queue_average((p + 1 < w - k) ? p + 1 : w - k, nch, k == off);
            end
            for (int c = 0; c < CHANNELS; c++) begin
                lane_sum[c] = '0;
            end
            line_pos = 0;
        end else begin
            line_pos = (p + 1 < MAX_WIDTH) ? p + 1 : MAX_WIDTH;
        end
        ring_slot = (slot + 1) % MAX_WIDTH;
    endfunction

    function automatic void check_field(string name, logic [CHAN_W-1:0] want,
                                        logic [CHAN_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Compare each accepted output pixel and drive the output stall
    always @(posedge i_clk) begin : out_monitor
        t_blur_px want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (blur_expect.size() == 0) begin
                $error("output pixel with no expected request pending");
                err_count++;
            end else begin
                want = blur_expect.pop_front();
                check_field("chan_a_out", want.lane[0], o_chan_a_out);
                check_field("chan_b_out", want.lane[1], o_chan_b_out);
                check_field("chan_c_out", want.lane[2], o_chan_c_out);
                check_field("chan_d_out", want.lane[3], o_chan_d_out);
                check_field("out_line_end", CHAN_W'(want.last), CHAN_W'(o_out_line_end));
            end
        end
        i_out_stall <= (sink_stall_pct > 0) && ($urandom_range(99) < sink_stall_pct);
    end

    // Send one pixel request and hold it until accepted
    task automatic send_pixel(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b,
                              input logic [CHAN_W-1:0] c, input logic [CHAN_W-1:0] d,
                              input logic last);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_chan_a_in <= a;
        i_chan_b_in <= b;
        i_chan_c_in <= c;
        i_chan_d_in <= d;
        i_line_end  <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_blur({d, c, b, a}, last);
    endtask

    // Drop valid and wait until every expected pixel is out and the block is quiet
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (blur_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIN_WIDTH:     set_width      = value[BW_W-1:0];
            REG_EVEN_SIDE:     set_lean_right = value[0];
            REG_CHANNEL_COUNT: set_lanes      = value[NCH_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input int width, input int lean_right, input int lanes);
        write_reg(REG_WIN_WIDTH, APB_W'(width));
        write_reg(REG_EVEN_SIDE, APB_W'(lean_right));
        write_reg(REG_CHANNEL_COUNT, APB_W'(lanes));
    endtask

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_line(input int len);
        for (int i = 0; i < len; i++) begin
            send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), i == len - 1);
        end
    endtask

    // Reset configuration: width 3, leaning left, three lanes
    task automatic test_reset_defaults();
        send_pixel(8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        drain_results();
    endtask

    // Zero width acts as one; a one-pixel line
    task automatic test_narrow_windows();
        set_config(0, 0, 4);
        send_pixel(8'd1, 8'd128, 8'd254, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd127, 8'd0, 8'd1, 1'b1);
        drain_results();
        set_config(1, 0, 4);
        send_pixel(8'd85, 8'd170, 8'd15, 8'd240, 1'b1);
        drain_results();
    endtask

    // Oversized width clamps to the maximum, oversized lane count to four
    task automatic test_wide_window();
        set_config(127, 1, 7);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd7, 8'd200, 8'd99, 8'd1, 1'b1);
        drain_results();
    endtask

    // Even widths leaning right and left
    task automatic test_even_lean();
        set_config(2, 1, 2);
        send_pixel(8'd10, 8'd11, 8'd12, 8'd13, 1'b0);
        send_pixel(8'd255, 8'd254, 8'd253, 8'd252, 1'b0);
        send_pixel(8'd3, 8'd0, 8'd255, 8'd9, 1'b1);
        drain_results();
        set_config(4, 0, 4);
        send_pixel(8'd200, 8'd1, 8'd55, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd254, 8'd201, 8'd128, 1'b1);
        drain_results();
    endtask

    // No lanes in use: every channel output is zero
    task automatic test_no_channels();
        set_config(5, 0, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd128, 8'd64, 8'd32, 8'd16, 1'b0);
        send_pixel(8'd1, 8'd2, 8'd4, 8'd8, 1'b1);
        drain_results();
    endtask

    // Narrow the window and add lanes in mid-line: sums wrap, averages saturate
    task automatic test_midline_changes();
        set_config(9, 0, 2);
        for (int i = 0; i < 5; i++) begin
            send_pixel(8'd250, 8'd240, 8'd230, 8'd220, 1'b0);
        end
        drain_results();
        set_config(2, 1, 4);
        send_pixel(8'd255, 8'd0, 8'd17, 8'd34, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd68, 8'd136, 1'b1);
        drain_results();
    endtask

    // Widest window leaning left on a long enough line: the largest flush
    task automatic test_full_flush();
        set_config(64, 0, 4);
        send_random_line(40);
        drain_results();
    endtask

    // Random lines, reconfigured now and then at a line boundary
    task automatic test_random_lines(input int n_items);
        int sent;
        int len;
        int width;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                drain_results();
                case ($urandom_range(9))
                    0:       width = 0;
                    1:       width = 64;
                    2:       width = $urandom_range(65, 127);
                    3:       width = $urandom_range(13, 63);
                    default: width = $urandom_range(1, 12);
                endcase
                set_config(width, $urandom_range(1), $urandom_range(7));
            end
            case ($urandom_range(9))
                0:       len = 1;
                7, 8:    len = $urandom_range(9, 40);
                9:       len = $urandom_range(65, 80);
                default: len = $urandom_range(2, 8);
            endcase
            send_random_line(len);
            sent += len;
        end
        drain_results();
    endtask

    // A line long enough to pin the line position at its limit
    task automatic test_long_line();
        set_config(5, 0, 4);
        send_random_line(LONG_LINE);
        drain_results();
    endtask

    initial begin
        set_width      = RST_WIN_WIDTH;
        set_lean_right = RST_EVEN_SIDE;
        set_lanes      = RST_CHANNEL_COUNT;
        line_pos       = 0;
        ring_slot      = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            lane_sum[c] = '0;
        end
        for (int i = 0; i < MAX_WIDTH; i++) begin
            px_ring[i] = '0;
        end

        src_idle_pct   = 18;
        sink_stall_pct = 47;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_narrow_windows();
        test_wide_window();
        test_even_lean();
        test_no_channels();
        test_midline_changes();
        test_full_flush();
        test_random_lines(55);

        src_idle_pct   = 47;
        sink_stall_pct = 18;
        test_random_lines(65);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_lines(55);
        test_long_line();

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
